// ===== rtl/core/nrsa_pkg.sv =====
package nrsa_pkg;

    // ascii codes the parser looks for
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // "$GNRMC" header
    localparam int unsigned HEADER_LEN = 6;

    // field positions counted by commas, header is field 0
    localparam logic [3:0] FIELD_STATUS = 4'd2;
    localparam logic [3:0] FIELD_SPEED  = 4'd7;
    localparam logic [3:0] FIELD_MAX    = 4'd15;

    // speed parsing
    localparam int unsigned FRACTION_DIGITS = 3;
    localparam logic [19:0] MAX_MILLIKNOTS = 20'd999999;

    // knots to km/h: floor(mk * 1852 / 1000) = floor(floor(mk * 463 / 2) / 125)
    localparam logic [8:0]  KNOT_SCALE     = 9'd463;
    localparam logic [28:0] DIV125_RECIP   = 29'd274877907;  // ceil(2^35 / 125)
    localparam int unsigned DIV125_SHIFT   = 35;
    localparam int unsigned KMH_WIDTH      = 21;

    // result codes
    localparam logic OUTCOME_RMC      = 1'b0;
    localparam logic OUTCOME_OVERFLOW = 1'b1;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // what one accepted byte hands to the conversion pipeline
    typedef struct packed {
        logic        hit;
        logic        outcome;
        logic        active;
        logic [19:0] milliknots;
    } parse_result_t;

    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h24;  // $
            3'd1:    b = 8'h47;  // G
            3'd2:    b = 8'h4E;  // N
            3'd3:    b = 8'h52;  // R
            3'd4:    b = 8'h4D;  // M
            3'd5:    b = 8'h43;  // C
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/nrsa_line_parser.sv =====
module nrsa_line_parser
    import nrsa_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output parse_result_t result
);

    localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] OVF_LEN = LEN_W'(LINE_BUFFER_BYTES - 1);
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_LEN);

    logic [LEN_W-1:0] line_len_reg, line_len_next;
    logic             header_match_reg, header_match_next;
    logic [3:0]       field_reg, field_next;
    logic             field_started_reg, field_started_next;
    logic             status_a_reg, status_a_next;
    logic             speed_present_reg, speed_present_next;
    logic             digits_done_reg, digits_done_next;
    logic             in_fraction_reg, in_fraction_next;
    logic [1:0]       frac_digits_reg, frac_digits_next;
    logic [19:0]      mk_reg, mk_next;

    logic             overflow;
    logic             is_dollar;
    logic             is_digit;
    logic [3:0]       digit;
    logic [23:0]      acc;
    logic [9:0]       frac_weight;

    assign overflow  = (line_len_reg >= OVF_LEN);
    assign is_dollar = (rx_byte == CHAR_DOLLAR);
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit     = 4'(rx_byte - CHAR_ZERO);

    always_comb
    begin
        case (frac_digits_reg)
            2'd0:    frac_weight = 10'd100;
            2'd1:    frac_weight = 10'd10;
            default: frac_weight = 10'd1;
        endcase
    end

    // one digit of the speed field: integer part shifts by ten, fraction adds by weight
    always_comb
    begin
        if (!in_fraction_reg)
        begin
            acc = {1'b0, mk_reg, 3'b000} + {3'b000, mk_reg, 1'b0} + 24'(digit) * 24'd1000;
        end
        else
        begin
            acc = 24'(mk_reg) + 24'(digit) * 24'(frac_weight);
        end
    end

    always_comb
    begin
        line_len_next      = line_len_reg;
        header_match_next  = header_match_reg;
        field_next         = field_reg;
        field_started_next = field_started_reg;
        status_a_next      = status_a_reg;
        speed_present_next = speed_present_reg;
        digits_done_next   = digits_done_reg;
        in_fraction_next   = in_fraction_reg;
        frac_digits_next   = frac_digits_reg;
        mk_next            = mk_reg;

        result.hit        = 1'b0;
        result.outcome    = OUTCOME_RMC;
        result.active     = speed_present_reg && status_a_reg;
        result.milliknots = speed_present_reg ? mk_reg : '0;

        if (accept)
        begin
            if (overflow)
            begin
                // line too long: drop the byte, clear the line
                result.hit         = 1'b1;
                result.outcome     = OUTCOME_OVERFLOW;
                result.active      = 1'b0;
                result.milliknots  = '0;
                line_len_next      = '0;
                header_match_next  = 1'b0;
                field_next         = '0;
                field_started_next = 1'b0;
                status_a_next      = 1'b0;
                speed_present_next = 1'b0;
                digits_done_next   = 1'b0;
                in_fraction_next   = 1'b0;
                frac_digits_next   = '0;
                mk_next            = '0;
            end
            else if (is_dollar)
            begin
                // closes the previous sentence and opens a new one
                result.hit         = header_match_reg && (line_len_reg >= HDR_LEN);
                line_len_next      = LEN_W'(1);
                header_match_next  = 1'b1;
                field_next         = '0;
                field_started_next = 1'b1;
                status_a_next      = 1'b0;
                speed_present_next = 1'b0;
                digits_done_next   = 1'b0;
                in_fraction_next   = 1'b0;
                frac_digits_next   = '0;
                mk_next            = '0;
            end
            else
            begin
                if (line_len_reg < HDR_LEN)
                begin
                    if (line_len_reg == '0)
                    begin
                        header_match_next = 1'b0;
                    end
                    else
                    begin
                        header_match_next = header_match_reg &&
                            (rx_byte == header_byte(line_len_reg[2:0]));
                    end
                end
                line_len_next = line_len_reg + LEN_W'(1);

                if (rx_byte == CHAR_COMMA)
                begin
                    if (field_reg != FIELD_MAX)
                    begin
                        field_next = field_reg + 4'd1;
                    end
                    field_started_next = 1'b0;
                end
                else
                begin
                    field_started_next = 1'b1;
                    if (field_reg == FIELD_STATUS && !field_started_reg)
                    begin
                        status_a_next = (rx_byte == CHAR_UPPER_A);
                    end
                    if (field_reg == FIELD_SPEED)
                    begin
                        speed_present_next = 1'b1;
                        if (!digits_done_reg)
                        begin
                            if (is_digit)
                            begin
                                if (!in_fraction_reg ||
                                    (32'(frac_digits_reg) < FRACTION_DIGITS &&
                                     frac_digits_reg != 2'd3))
                                begin
                                    mk_next = (acc > 24'(MAX_MILLIKNOTS)) ?
                                              MAX_MILLIKNOTS : acc[19:0];
                                end
                                if (in_fraction_reg && frac_digits_reg != 2'd3)
                                begin
                                    frac_digits_next = frac_digits_reg + 2'd1;
                                end
                            end
                            else if (rx_byte == CHAR_DOT && !in_fraction_reg)
                            begin
                                in_fraction_next = 1'b1;
                            end
                            else
                            begin
                                digits_done_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg      <= '0;
            header_match_reg  <= 1'b0;
            field_reg         <= '0;
            field_started_reg <= 1'b0;
            status_a_reg      <= 1'b0;
            speed_present_reg <= 1'b0;
            digits_done_reg   <= 1'b0;
            in_fraction_reg   <= 1'b0;
            frac_digits_reg   <= '0;
            mk_reg            <= '0;
        end
        else
        begin
            line_len_reg      <= line_len_next;
            header_match_reg  <= header_match_next;
            field_reg         <= field_next;
            field_started_reg <= field_started_next;
            status_a_reg      <= status_a_next;
            speed_present_reg <= speed_present_next;
            digits_done_reg   <= digits_done_next;
            in_fraction_reg   <= in_fraction_next;
            frac_digits_reg   <= frac_digits_next;
            mk_reg            <= mk_next;
        end
    end

endmodule

// ===== rtl/core/nmea_rmc_speed_alarm.sv =====
// channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------------------------
// input     | in_valid / in_stall       | rx_byte
// output    | out_valid / out_stall     | outcome, fix_active, speed_kmh_milli, command
// config    | cfg_wr_en                 | threshold_kmh
//
// one byte per cycle while in_stall is low; the line parser state updates in the accept cycle
// a result passes the parse register, which loads with the closing byte, then the x463
// multiply, the divide-by-125 multiply and the output register
// reset clears the line state, sets playing and loads a threshold of 3 km/h
// each stage holds while the one after it is full and stalled; in_stall only
// rises when the parse register itself cannot drain
module nmea_rmc_speed_alarm
    import nrsa_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 outcome,
    output logic                 fix_active,
    output logic [KMH_WIDTH-1:0] speed_kmh_milli,
    output logic [1:0]           command,

    input  logic                 cfg_wr_en,
    input  logic [7:0]           threshold_kmh
);

    // threshold register
    logic [7:0] threshold_reg;

    // playing flag, lives at the output stage so commands stay in order
    logic playing_reg, playing_next;

    // handshake
    logic accept;
    logic out_ready, s3_ready, s2_ready, s1_ready;

    parse_result_t parse_res;

    // stage 1: sentence result held in milliknots
    logic        s1_valid_reg;
    logic        s1_outcome_reg;
    logic        s1_active_reg;
    logic [19:0] s1_mk_reg;

    // stage 2: milliknots * 463 / 2
    logic        s2_valid_reg;
    logic        s2_outcome_reg;
    logic        s2_active_reg;
    logic [27:0] s2_half_reg;
    logic [28:0] s2_prod;

    // stage 3: divided by 125 gives thousandths of km/h
    logic                 s3_valid_reg;
    logic                 s3_outcome_reg;
    logic                 s3_active_reg;
    logic [KMH_WIDTH-1:0] s3_kmh_reg;
    logic [56:0]          s3_prod;

    // output register
    logic                 out_valid_reg;
    logic                 outcome_reg;
    logic                 fix_active_reg;
    logic [KMH_WIDTH-1:0] kmh_reg;
    logic [1:0]           command_reg;
    logic [1:0]           command_next;

    logic [KMH_WIDTH-1:0] threshold_milli;
    logic                 at_speed;

    // ready chain, a stage takes new data when empty or when it drains this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && !in_stall;

    nrsa_line_parser #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .rx_byte(rx_byte),
        .result (parse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 8'd3;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= threshold_kmh;
        end
    end

    // conversion datapath
    assign s2_prod = 29'(s1_mk_reg) * 29'(KNOT_SCALE);
    assign s3_prod = 57'(s2_half_reg) * 57'(DIV125_RECIP);

    // threshold compare and playing flag update at the output register load
    assign threshold_milli = KMH_WIDTH'(threshold_reg) * KMH_WIDTH'(1000);
    assign at_speed        = (s3_kmh_reg >= threshold_milli);

    always_comb
    begin
        playing_next = playing_reg;
        command_next = CMD_NONE;
        if (s3_valid_reg && out_ready && s3_outcome_reg == OUTCOME_RMC)
        begin
            if (at_speed && !playing_reg)
            begin
                playing_next = 1'b1;
                command_next = CMD_START;
            end
            else if (!at_speed && playing_reg)
            begin
                playing_next = 1'b0;
                command_next = CMD_STOP;
            end
        end
    end

    // valid bits and playing flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            playing_reg   <= 1'b1;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= accept && parse_res.hit;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            playing_reg <= playing_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_outcome_reg <= parse_res.outcome;
            s1_active_reg  <= parse_res.active;
            s1_mk_reg      <= parse_res.milliknots;
        end
        if (s2_ready)
        begin
            s2_outcome_reg <= s1_outcome_reg;
            s2_active_reg  <= s1_active_reg;
            s2_half_reg    <= s2_prod[28:1];
        end
        if (s3_ready)
        begin
            s3_outcome_reg <= s2_outcome_reg;
            s3_active_reg  <= s2_active_reg;
            s3_kmh_reg     <= s3_prod[DIV125_SHIFT+KMH_WIDTH-1:DIV125_SHIFT];
        end
        if (out_ready)
        begin
            outcome_reg    <= s3_outcome_reg;
            fix_active_reg <= s3_active_reg;
            kmh_reg        <= s3_kmh_reg;
            command_reg    <= command_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign fix_active      = fix_active_reg;
    assign speed_kmh_milli = kmh_reg;
    assign command         = command_reg;

    // overflow items carry no speed and never switch playback
    a_overflow_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && outcome_reg == OUTCOME_OVERFLOW |->
            command_reg == CMD_NONE && kmh_reg == '0 && !fix_active_reg)
        else $error("overflow item carries speed or command");

    // a start leaves playback on, a stop leaves it off
    a_cmd_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (command_reg == CMD_START || command_reg == CMD_STOP) |->
            playing_reg == (command_reg == CMD_START))
        else $error("command disagrees with playing flag");

    // the input only stalls behind a full parse register
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg)
        else $error("input stalled with room in the pipeline");

    // converted speed stays within saturated milliknots
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> kmh_reg <= KMH_WIDTH'(1851998))
        else $error("speed beyond saturated range");

endmodule

// ===== verif/rmc_alarm_checker.sv =====
module rmc_alarm_checker
    import nrsa_pkg::*;
#(
    parameter int LINE_BUFFER_BYTES = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [7:0]           rx_byte,

    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 outcome,
    input  logic                 fix_active,
    input  logic [KMH_WIDTH-1:0] speed_kmh_milli,
    input  logic [1:0]           command,

    input  logic                 cfg_wr_en,
    input  logic [7:0]           threshold_kmh,

    output int                   mismatches,
    output int                   alarms_pending,
    output int                   alarms_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 outcome;
        logic                 fix;
        logic [KMH_WIDTH-1:0] kmh;
        logic [1:0]           cmd;
    } alarm_t;

    localparam logic [47:0] RMC_TAG            = "$GNRMC";
    localparam logic [7:0]  THRESHOLD_AT_RESET = 8'd3;

    alarm_t      expected_alarms[$];

    logic [7:0]  threshold;
    logic [8:0]  line_len;
    logic        tag_ok;
    logic [3:0]  field_no;
    logic        status_a;
    logic        speed_seen;
    logic        speed_done;
    logic        in_frac;
    logic [1:0]  frac_cnt;
    logic [19:0] milliknots;
    logic        playing;
    logic        field_begun;

    function automatic void clear_sentence();
        line_len    = '0;
        tag_ok      = 1'b0;
        field_no    = '0;
        status_a    = 1'b0;
        speed_seen  = 1'b0;
        speed_done  = 1'b0;
        in_frac     = 1'b0;
        frac_cnt    = '0;
        milliknots  = '0;
        field_begun = 1'b0;
    endfunction

    function automatic logic [19:0] clip_knots(input longint unsigned v);
        return (v > MAX_MILLIKNOTS) ? MAX_MILLIKNOTS : v[19:0];
    endfunction

    function automatic void take_speed_char(input logic [7:0] c);
        longint unsigned m;
        longint unsigned d;
        longint unsigned w;
        m = milliknots;
        speed_seen = 1'b1;
        if (speed_done)
            return;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            if (!in_frac) begin
                milliknots = clip_knots(m * 10 + d * 1000);
            end
            else begin
                // tenths, hundredths, thousandths; deeper digits are ignored
                if (frac_cnt < FRACTION_DIGITS) begin
                    w = (frac_cnt == 2'd0) ? 100 : ((frac_cnt == 2'd1) ? 10 : 1);
                    milliknots = clip_knots(m + d * w);
                end
                if (frac_cnt < 2'd3)
                    frac_cnt++;
            end
        end
        else if (c == CHAR_DOT && !in_frac) begin
            in_frac = 1'b1;
        end
        else begin
            speed_done = 1'b1;
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int idx;
        idx = line_len;
        if (idx < HEADER_LEN) begin
            if (idx == 0)
                tag_ok = (c == RMC_TAG[47 -: 8]);
            else
                tag_ok = tag_ok && (c == RMC_TAG[47 - 8 * idx -: 8]);
        end
        line_len++;
        if (c == CHAR_COMMA) begin
            if (field_no < FIELD_MAX)
                field_no++;
            field_begun = 1'b0;
            return;
        end
        if (field_no == FIELD_STATUS && !field_begun)
            status_a = (c == CHAR_UPPER_A);
        if (field_no == FIELD_SPEED)
            take_speed_char(c);
        field_begun = 1'b1;
    endfunction

    // one accepted byte: update the line state, queue the alarm it causes if any
    function automatic void predict_alarm(input logic [7:0] c);
        alarm_t          a;
        longint unsigned kmh;
        longint unsigned limit;
        if (line_len >= LINE_BUFFER_BYTES - 1) begin
            clear_sentence();
            a = '{outcome: OUTCOME_OVERFLOW, fix: 1'b0, kmh: '0, cmd: CMD_NONE};
            expected_alarms = {expected_alarms, a};
            return;
        end
        if (c == CHAR_DOLLAR) begin
            if (tag_ok && line_len >= HEADER_LEN) begin
                kmh = milliknots;
                kmh = speed_seen ? (kmh * 1852) / 1000 : 0;
                limit = threshold;
                limit = limit * 1000;
                a.outcome = OUTCOME_RMC;
                a.fix     = speed_seen && status_a;
                a.kmh     = kmh[KMH_WIDTH-1:0];
                a.cmd     = CMD_NONE;
                if (kmh >= limit) begin
                    if (!playing) begin
                        playing = 1'b1;
                        a.cmd   = CMD_START;
                    end
                end
                else if (playing) begin
                    playing = 1'b0;
                    a.cmd   = CMD_STOP;
                end
                expected_alarms = {expected_alarms, a};
            end
            clear_sentence();
        end
        take_char(c);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        alarm_t want;
        if (!rst_n) begin
            threshold = THRESHOLD_AT_RESET;
            clear_sentence();
            playing = 1'b1;
            expected_alarms.delete();
            alarms_pending <= 0;
        end
        else begin
            if (cfg_wr_en)
                threshold = threshold_kmh;
            if (in_valid && !in_stall)
                predict_alarm(rx_byte);
            if (out_valid && !out_stall) begin
                alarms_checked++;
                if (expected_alarms.size() == 0) begin
                    $error("unexpected item: outcome %0d fix %0d speed %0d command %0d",
                           outcome, fix_active, speed_kmh_milli, command);
                    mismatches++;
                end
                else begin
                    want = expected_alarms.pop_front();
                    check_field("outcome", want.outcome, outcome);
                    check_field("fix_active", want.fix, fix_active);
                    check_field("speed_kmh_milli", want.kmh, speed_kmh_milli);
                    check_field("command", want.cmd, command);
                end
            end
            alarms_pending <= expected_alarms.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // receiver hold-off used to back the pipeline up into in_stall
    localparam int HOLD_CYCLES     = 200;
    // extra wait once every expected result has arrived; leave a margin
    localparam int DRAIN_CYCLES    = 10;
    localparam int SETTLE_LIMIT    = 5000;
    // a random phase runs until it has sent this many bytes and sentences
    localparam int PHASE_BYTES       = 30;
    localparam int FINAL_PHASE_BYTES = 120;
    localparam int PHASE_SENTENCES   = 1;
    // prefix length that long_line puts before its filler
    localparam int LONG_PREFIX     = 18;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [7:0]                    rx_byte;
    logic                          out_valid;
    logic                          out_stall;
    logic                          outcome;
    logic                          fix_active;
    logic [nrsa_pkg::KMH_WIDTH-1:0] speed_kmh_milli;
    logic [1:0]                    command;
    logic                          cfg_wr_en;
    logic [7:0]                    thr_value;

    int mismatches;
    int alarms_pending;
    int alarms_checked;

    // pacing knobs for the sender and the receiver
    int idle_pct    = 38;
    int stall_pct   = 38;
    int hold_reqs   = 0;
    int hold_served = 0;

    // bookkeeping for the summary and for ending each phase
    int bytes_sent     = 0;
    int rmc_sent       = 0;
    int overflow_lines = 0;
    logic [7:0] mid_threshold;

    nmea_rmc_speed_alarm uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .outcome             (outcome),
        .fix_active          (fix_active),
        .speed_kmh_milli     (speed_kmh_milli),
        .command             (command),
        .cfg_wr_en           (cfg_wr_en),
        .threshold_kmh       (thr_value)
    );

    rmc_alarm_checker alarm_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .outcome             (outcome),
        .fix_active          (fix_active),
        .speed_kmh_milli     (speed_kmh_milli),
        .command             (command),
        .cfg_wr_en           (cfg_wr_en),
        .threshold_kmh       (thr_value),
        .mismatches          (mismatches),
        .alarms_pending      (alarms_pending),
        .alarms_checked      (alarms_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus a long hold whenever the sender asks for one
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_served) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // offer one byte, with a random gap first, and wait until it is taken
    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [7:0] any_but_dollar();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == nrsa_pkg::CHAR_DOLLAR)
            b = 8'hA4;
        return b;
    endfunction

    // a printable character that cannot split a field or a sentence
    function automatic string plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(33, 126));
        if (b == nrsa_pkg::CHAR_DOLLAR || b == nrsa_pkg::CHAR_COMMA)
            b = "*";
        return $sformatf("%c", b);
    endfunction

    // rmc line with a valid speed, padded with raw bytes to the given length
    task automatic long_line(input int total);
        put_text("$GNRMC,,A,,,,,4.2,");
        repeat (total - LONG_PREFIX) put_byte(any_but_dollar());
        if (total >= 255)
            overflow_lines++;
    endtask

    // drop valid, let every expected result arrive, then let the pipe empty
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (alarms_pending != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [7:0] v);
        settle();
        cfg_wr_en <= 1'b1;
        thr_value <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic string status_text();
        string s;
        case ($urandom_range(0, 5))
            0, 1:    s = "A";
            2:       s = "V";
            3:       s = "";
            4:       s = "AV";
            default: s = plain_char();
        endcase
        return s;
    endfunction

    // speed field text; some land right at the current threshold
    function automatic string speed_text();
        string       s;
        int unsigned mk;
        case ($urandom_range(0, 9))
            0: s = "";
            1, 2:
            begin
                mk = thr_value;
                mk = mk * 1000000 / 1852 + $urandom_range(0, 4);
                if (mk >= 2)
                    mk = mk - 2;
                s = $sformatf("%0d.%03d", mk / 1000, mk % 1000);
            end
            3: s = $sformatf("%0d.%0d", $urandom_range(0, 9999999), $urandom_range(0, 99));
            4: s = $sformatf(".%0d", $urandom_range(0, 99999));
            5: s = $sformatf("%0d", $urandom_range(0, 300));
            6: s = $sformatf("%0d.", $urandom_range(0, 150));
            default: s = $sformatf("%0d.%0d", $urandom_range(0, 200), $urandom_range(0, 99999));
        endcase
        // sometimes a terminator and trailing junk after the number
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
                0:       s = {s, "-7"};
                1:       s = {s, "+3"};
                2:       s = {s, " 9"};
                3:       s = {s, ".5"};
                default: s = {s, plain_char(), "1"};
            endcase
        end
        return s;
    endfunction

    function automatic string rmc_sentence();
        string fix_time;
        string pos;
        string tail;
        fix_time = ($urandom_range(0, 2) == 0) ? "" :
                   $sformatf("%06d", $urandom_range(0, 235959));
        pos  = ($urandom_range(0, 3) == 0) ? "4807.03,N,01131.00,E" : ",,,";
        tail = ($urandom_range(0, 3) == 0) ? ",084.4,230394,003.1,W*6A" : "";
        return {"$GNRMC,", fix_time, ",", status_text(), ",", pos, ",", speed_text(), tail};
    endfunction

    function automatic string other_header();
        string s;
        case ($urandom_range(0, 5))
            0:       s = "$GPRMC";
            1:       s = "$GNRMB";
            2:       s = "$GNRM";
            3:       s = "$GNGGA";
            4:       s = "$gnrmc";
            default: s = "GNRMC";
        endcase
        return s;
    endfunction

    // one random chunk of stream: mostly good rmc, the rest noise and broken lines
    task automatic random_chunk();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 68) begin
            put_text(rmc_sentence());
            rmc_sent++;
        end
        else if (kind < 78) begin
            put_text({other_header(), ",,", status_text(), ",,,,,", speed_text()});
        end
        else if (kind < 90) begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 92) begin
            long_line($urandom_range(253, 258));
        end
        else begin
            // raw byte inside the speed field
            put_text({"$GNRMC,,A,,,,,", $sformatf("%0d", $urandom_range(0, 99))});
            put_byte(any_but_dollar());
            put_text($sformatf("%0d", $urandom_range(0, 9)));
            rmc_sent++;
        end
    endtask

    task automatic run_phase(input logic [7:0] thr, input bit squeeze, input int min_bytes);
        int start_bytes;
        int start_rmc;
        set_threshold(thr);
        start_bytes = bytes_sent;
        start_rmc   = rmc_sent;
        while (bytes_sent - start_bytes < min_bytes || rmc_sent - start_rmc < PHASE_SENTENCES)
        begin
            if (squeeze) begin
                // back-to-back minimal sentences while the receiver holds off
                hold_reqs <= hold_reqs + 1;
                repeat (16) put_text("$GNRMC");
                rmc_sent += 16;
                squeeze = 1'b0;
            end
            random_chunk();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        cfg_wr_en <= 1'b0;
        thr_value <= 8'd3;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset threshold of 3 km/h, playing after reset
        // each sentence is closed by the dollar of the next one
        put_text("$GNRMC,,A,,,,,1.619");        // just below threshold, stop
        put_text("$GNRMC,,A,,,,,1.620");        // exactly at threshold, start
        put_text("$GNRMC,,V,,,,,1.620");        // void fix, no change
        put_text("$GNRMC,,A,,,,,");             // empty speed, stop
        put_text("$GNRMC,,A,,,,,9999999.9999"); // saturation, start
        put_text("$GNRMC,,AV,,,,,.5678");       // only first status byte counts, extra digit
        put_text("$GNRMC,,VA,,,,,1.2.3");       // second dot ends the number
        put_text("$GNRMC,,A,,,,,-5");           // sign ends the number at once
        put_text("$GNRMC,,A,,,,, 4");           // leading space
        put_text("$GNRMC,,A,,,,,12+5");
        put_text("$GNRMC,,A,,,,,2,,,,,,,,,,,,,,,,,,3"); // field count saturates
        put_text("$GNRMC,,A,,,,,1");
        put_byte(8'h00);                        // nul is an ordinary byte
        put_text("5");
        put_byte(8'hFF);
        put_text("$GPRMC,,A,,,,,50");           // other talker, no result
        put_text("$GN");                        // short line, no result
        put_text("$");                          // single-byte line
        put_text("$GNRMC");                     // header only
        put_text("$GNRMC,,,,,,,,");             // speed field empty but present
        put_text("$GNRMC,,A,,,,,0.0009");       // fourth fraction digit ignored
        long_line(254);                         // longest line that still gets evaluated
        long_line(255);                         // the closing dollar is dropped
        put_text("$GNRMC,,A,,,,,80");           // headerless after the overflow
        long_line(257);                         // overflow on an ordinary byte
        put_text("$GNRMC,,A,,,,,80");

        // random phases over several thresholds, extremes included
        mid_threshold = 8'($urandom_range(2, 254));
        run_phase(8'd0, 1'b0, PHASE_BYTES);
        run_phase(8'd255, 1'b0, PHASE_BYTES);
        run_phase(mid_threshold, 1'b1, PHASE_BYTES);
        run_phase(8'd1, 1'b0, PHASE_BYTES);
        // long stretch with neither side idling
        idle_pct  = 0;
        stall_pct = 0;
        run_phase(8'd3, 1'b0, FINAL_PHASE_BYTES);

        // close the last sentence and wait for everything in flight
        put_byte(nrsa_pkg::CHAR_DOLLAR);
        settle();

        $display("covered %0d bytes, %0d rmc sentences, %0d overflow lines",
                 bytes_sent, rmc_sent, overflow_lines);
        $display("%0d results compared at thresholds 0, 1, 3, %0d and 255",
                 alarms_checked, mid_threshold);
        if (alarms_pending != 0)
            $error("%0d expected results never arrived", alarms_pending);
        if (mismatches == 0 && alarms_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
